// ----- rtl/core/host_power_supervisor_defines.svh -----
// Assertion macros shared by the supervisor RTL.
// Every macro samples on the rising edge of clk and is held off while arst_n is low.
`ifndef HOST_POWER_SUPERVISOR_DEFINES_SVH
`define HOST_POWER_SUPERVISOR_DEFINES_SVH

// A property that must hold at every clock edge.
`define HPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define HPS_ASSERT_IMP(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/hps_pkg.sv -----
`timescale 1ns / 1ps

package hps_pkg;

	// Item kinds as decoded by the front end
	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_WAKE = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// One decoded item on its way to the back end
	typedef struct packed {
		kind_t      kind;
		logic [7:0] bus_byte;
	} cmd_t;

	// Supervisor phase, one-hot
	typedef enum logic [3:0] {
		PH_RUN   = 4'b0001,
		PH_DOWN  = 4'b0010,
		PH_OFF   = 4'b0100,
		PH_SLEEP = 4'b1000
	} phase_t;

	// Phase codes as reported in the result word
	localparam logic [1:0] PCODE_RUN   = 2'd0;
	localparam logic [1:0] PCODE_DOWN  = 2'd1;
	localparam logic [1:0] PCODE_OFF   = 2'd2;
	localparam logic [1:0] PCODE_SLEEP = 2'd3;

	// Raw opcodes on the input channel
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_WAKE = 2'd2;

	// Command types carried by the first byte of a pair
	localparam logic [7:0] CMD_DELAY = 8'd0;
	localparam logic [7:0] CMD_BOOT  = 8'd1;

	// Configuration register indexes
	localparam logic [1:0] REG_BOOT_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_CYCLE_OFF    = 2'd1;
	localparam logic [1:0] REG_TICKS_PER_S  = 2'd2;

	// Configuration reset values
	localparam logic [11:0] RST_BOOT_TIMEOUT = 12'd1200;
	localparam logic [11:0] RST_CYCLE_OFF    = 12'd100;
	localparam logic [3:0]  RST_TICKS_PER_S  = 4'd5;

	localparam logic [11:0] CNT_MAX = 12'hFFF;

	// Queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// Result word fields
	typedef struct packed {
		logic       watchdog_fired;
		logic       boot_seen;
		logic [1:0] phase;
		logic       power_enable;
	} status_t;

	// Configuration write bundle
	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [11:0] data;
	} cfg_wr_t;

endpackage

// ----- rtl/core/hps_front.sv -----
`timescale 1ns / 1ps

module hps_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_opcode,
	input  logic [7:0]    in_byte,
	output logic          push,
	output hps_pkg::cmd_t push_cmd,
	input  logic          q_full
);

	logic          valid_s1;
	hps_pkg::cmd_t cmd_s1;
	hps_pkg::kind_t kind;

	// Decode the raw opcode into an item kind.
	always_comb begin
		unique case (in_opcode)
			hps_pkg::OP_TICK: kind = hps_pkg::KIND_TICK;
			hps_pkg::OP_BYTE: kind = hps_pkg::KIND_BYTE;
			hps_pkg::OP_WAKE: kind = hps_pkg::KIND_WAKE;
			default:          kind = hps_pkg::KIND_NONE;
		endcase
	end

	// The stage frees up whenever its word moves into the queue.
	assign push     = valid_s1 && !q_full;
	assign push_cmd = cmd_s1;
	assign in_ready = !valid_s1 || !q_full;

	// Valid flag of the decode stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the decode stage.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.kind     <= kind;
			cmd_s1.bus_byte <= in_byte;
		end
	end

endmodule

// ----- rtl/core/hps_queue.sv -----
`timescale 1ns / 1ps
`include "host_power_supervisor_defines.svh"

module hps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hps_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output hps_pkg::cmd_t head
);

	localparam int PTR_W = $clog2(hps_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(hps_pkg::QUEUE_DEPTH + 1);

	hps_pkg::cmd_t    mem_q [hps_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(hps_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage for queued words.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(hps_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(hps_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// The fill count never passes the depth, and a word is only taken when present.
	`HPS_ASSERT(a_q_cnt, cnt_q <= CNT_W'(hps_pkg::QUEUE_DEPTH), "queue count over depth")
	`HPS_ASSERT_IMP(a_q_pop, pop, !empty, "pop from empty queue")

endmodule

// ----- rtl/core/hps_back.sv -----
`timescale 1ns / 1ps
`include "host_power_supervisor_defines.svh"

module hps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hps_pkg::cfg_wr_t cfg,
	input  logic             q_empty,
	input  hps_pkg::cmd_t    head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output hps_pkg::status_t out_status
);

	// Configuration registers
	logic [11:0] boot_timeout_q;
	logic [11:0] cycle_off_q;
	logic [3:0]  tps_q;

	// Supervisor state
	hps_pkg::phase_t phase_q, phase_d;
	logic        boot_q, boot_d;
	logic [11:0] unbooted_q, unbooted_d;
	logic [7:0]  pending_q, pending_d;
	logic [11:0] timer_q, timer_d;
	logic        second_q, second_d;
	logic [7:0]  held_q, held_d;
	logic        fired;
	logic [11:0] delay_ticks;
	logic [1:0]  pcode;

	// Result register
	logic             out_valid_q;
	hps_pkg::status_t out_q;

	assign pop        = !q_empty && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_status = out_q;

	// Shutdown delay in ticks; at most 255 * 15, so it fits twelve bits.
	assign delay_ticks = 12'(pending_q) * 12'(tps_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_timeout_q <= hps_pkg::RST_BOOT_TIMEOUT;
			cycle_off_q    <= hps_pkg::RST_CYCLE_OFF;
			tps_q          <= hps_pkg::RST_TICKS_PER_S;
		end else if (cfg.we) begin
			unique case (cfg.index)
				hps_pkg::REG_BOOT_TIMEOUT: boot_timeout_q <= cfg.data;
				hps_pkg::REG_CYCLE_OFF:    cycle_off_q    <= cfg.data;
				hps_pkg::REG_TICKS_PER_S:  tps_q          <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Next state for the item at the head of the queue.
	always_comb begin
		phase_d    = phase_q;
		boot_d     = boot_q;
		unbooted_d = unbooted_q;
		pending_d  = pending_q;
		timer_d    = timer_q;
		second_d   = second_q;
		held_d     = held_q;
		fired      = 1'b0;
		unique case (head.kind)
			hps_pkg::KIND_TICK: begin
				unique case (phase_q) inside
					hps_pkg::PH_RUN: begin
						if (!boot_q && (unbooted_q > boot_timeout_q
							|| unbooted_q == hps_pkg::CNT_MAX)) begin
							phase_d = hps_pkg::PH_OFF;
							timer_d = cycle_off_q;
							fired   = 1'b1;
						end else if (pending_q != '0) begin
							if (delay_ticks == '0) begin
								pending_d = '0;
								timer_d   = '0;
								phase_d   = hps_pkg::PH_SLEEP;
							end else begin
								timer_d = delay_ticks;
								phase_d = hps_pkg::PH_DOWN;
							end
						end else if (!boot_q && unbooted_q != hps_pkg::CNT_MAX) begin
							unbooted_d = unbooted_q + 12'd1;
						end
					end
					hps_pkg::PH_DOWN, hps_pkg::PH_OFF: begin
						if (timer_q <= 12'd1) begin
							timer_d   = '0;
							pending_d = '0;
							if (phase_q == hps_pkg::PH_DOWN) begin
								phase_d = hps_pkg::PH_SLEEP;
							end else begin
								// The tick that ends the forced cycle counts as unbooted.
								phase_d    = hps_pkg::PH_RUN;
								boot_d     = 1'b0;
								unbooted_d = 12'd1;
							end
						end else begin
							timer_d = timer_q - 12'd1;
						end
					end
					default: ;
				endcase
			end
			hps_pkg::KIND_BYTE: begin
				// Bytes are dropped while asleep and pairing stays put.
				if (phase_q != hps_pkg::PH_SLEEP) begin
					if (!second_q) begin
						held_d   = head.bus_byte;
						second_d = 1'b1;
					end else begin
						second_d = 1'b0;
						if (held_q == hps_pkg::CMD_DELAY) begin
							pending_d = head.bus_byte;
						end else if (held_q == hps_pkg::CMD_BOOT) begin
							boot_d = 1'b1;
						end
					end
				end
			end
			hps_pkg::KIND_WAKE: begin
				if (phase_q == hps_pkg::PH_SLEEP) begin
					phase_d    = hps_pkg::PH_RUN;
					boot_d     = 1'b0;
					unbooted_d = 12'd1;
				end
			end
			default: ;
		endcase
	end

	// Reported code of the new phase.
	always_comb begin
		unique case (phase_d)
			hps_pkg::PH_RUN:   pcode = hps_pkg::PCODE_RUN;
			hps_pkg::PH_DOWN:  pcode = hps_pkg::PCODE_DOWN;
			hps_pkg::PH_OFF:   pcode = hps_pkg::PCODE_OFF;
			default:           pcode = hps_pkg::PCODE_SLEEP;
		endcase
	end

	// Supervisor state update, one item per cycle while an item waits and the result register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= hps_pkg::PH_RUN;
			boot_q     <= 1'b0;
			unbooted_q <= '0;
			pending_q  <= '0;
			timer_q    <= '0;
			second_q   <= 1'b0;
			held_q     <= '0;
		end else if (pop) begin
			phase_q    <= phase_d;
			boot_q     <= boot_d;
			unbooted_q <= unbooted_d;
			pending_q  <= pending_d;
			timer_q    <= timer_d;
			second_q   <= second_d;
			held_q     <= held_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= pop;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.power_enable   <= (pcode == hps_pkg::PCODE_RUN)
				|| (pcode == hps_pkg::PCODE_DOWN);
			out_q.phase          <= pcode;
			out_q.boot_seen      <= boot_d;
			out_q.watchdog_fired <= fired;
		end
	end

	// A fired watchdog always reports the forced-off phase with power cut.
	`HPS_ASSERT_IMP(a_fire_off, out_valid_q && out_q.watchdog_fired,
		out_q.phase == hps_pkg::PCODE_OFF && !out_q.power_enable, "watchdog without cut")
	// The phase timer only holds a count during countdown or forced off.
	`HPS_ASSERT_IMP(a_timer_idle, phase_q == hps_pkg::PH_RUN || phase_q == hps_pkg::PH_SLEEP,
		timer_q == '0, "phase timer left running")

endmodule

// ----- rtl/core/host_power_supervisor.sv -----
`timescale 1ns / 1ps
// Host power supervisor.
// Input channel s_*: one word per event. s_tuser carries the opcode (tick, bus
// byte, alarm wake edge), s_tdata the received bus byte. Bus bytes pair into
// commands: a type byte then a data byte (delay in seconds, or boot seen).
// Output channel m_*: one status word for every input word, in order.
// Configuration: cfg_we, cfg_index and cfg_data write the boot timeout, the
// forced-off length and the ticks per second; write only while the block idles.
// Path: an accepted word passes through the decode stage, the queue and the
// result register, in that order, before its status word is offered.
// Throughput: one word per cycle while m_tready stays high; the state update in
// the back end handles one item per cycle, with a two-word queue between decoder and back end.
// Reset: arst_n clears all state; the host is powered, unbooted, with the
// configuration at its defaults (1200, 100, 5 ticks).
// Stalls: while m_tready is low the status word holds, the queue fills and
// then s_tready drops; no word is lost or repeated.
module host_power_supervisor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] bus_byte
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] power_enable, [2:1] phase, [3] boot_seen,
	                               // [4] watchdog_fired, [7:5] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	logic             push;
	hps_pkg::cmd_t    push_cmd;
	logic             q_full;
	logic             q_empty;
	hps_pkg::cmd_t    head;
	logic             pop;
	hps_pkg::status_t status;
	hps_pkg::cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Decode stage
	hps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser),
		.in_byte   (s_tdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	// Queue between decode and execution
	hps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	// Supervisor state and result register
	hps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status)
	);

	// Pack the status word, power_enable in the lowest bit and zero padding on top.
	assign m_tdata = {3'b000, status.watchdog_fired, status.boot_seen, status.phase,
		status.power_enable};

endmodule

// ----- bench/host_power_supervisor_test.sv -----
`timescale 1ns / 1ps

module host_power_supervisor_test;

	localparam int         LIMIT_CYCLES  = 1000000;
	localparam int         SETTLE_CYCLES = 6;
	localparam logic [1:0] OP_SPARE      = 2'd3;

	// One row of the directed table: either a register update or one input word.
	typedef struct packed {
		bit               reconf;
		logic [11:0]      timeout;
		logic [11:0]      off_len;
		logic [3:0]       tps;
		logic [1:0]       op;
		logic [7:0]       data;
		bit               typed;
		hps_pkg::status_t want;
	} step_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic [1:0]  s_tuser   = hps_pkg::OP_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = hps_pkg::REG_BOOT_TIMEOUT;
	logic [11:0] cfg_data  = 12'd0;

	int               errors        = 0;
	int               cycles        = 0;
	int               live_words    = 0;
	int               checked_words = 0;
	bit               feed_idle     = 1'b0;
	bit               drain_idle    = 1'b0;
	hps_pkg::status_t status_due[$];
	step_t            steps[$];

	// Mirror of the supervisor state and its registers.
	logic [1:0]  sup_phase;
	bit          sup_booted;
	logic [11:0] sup_unbooted;
	logic [7:0]  sup_delay;
	logic [11:0] sup_timer;
	bit          sup_data_next;
	logic [7:0]  sup_type;
	logic [11:0] cfg_timeout_q;
	logic [11:0] cfg_off_q;
	logic [3:0]  cfg_tps_q;

	host_power_supervisor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic hps_pkg::status_t word_of(logic pwr, logic [1:0] ph, logic boot,
			logic wd);
		hps_pkg::status_t s;
		s.power_enable   = pwr;
		s.phase          = ph;
		s.boot_seen      = boot;
		s.watchdog_fired = wd;
		return s;
	endfunction

	// A row whose status word is typed in.
	function automatic step_t want_row(logic [1:0] op, logic [7:0] data, logic pwr,
			logic [1:0] ph, logic boot, logic wd);
		step_t r;
		r = '0;
		r.op    = op;
		r.data  = data;
		r.typed = 1'b1;
		r.want  = word_of(pwr, ph, boot, wd);
		return r;
	endfunction

	// A row checked against the predictor.
	function automatic step_t plain_row(logic [1:0] op, logic [7:0] data);
		step_t r;
		r = '0;
		r.op   = op;
		r.data = data;
		return r;
	endfunction

	function automatic step_t cfg_row(logic [11:0] timeout, logic [11:0] off_len,
			logic [3:0] tps);
		step_t r;
		r = '0;
		r.reconf  = 1'b1;
		r.timeout = timeout;
		r.off_len = off_len;
		r.tps     = tps;
		return r;
	endfunction

	// Advances the mirrored state by one input word and returns the status word it gives.
	function automatic hps_pkg::status_t supervise(logic [1:0] op, logic [7:0] b);
		logic        fired;
		int unsigned prod;
		fired = 1'b0;
		case (op)
			hps_pkg::OP_TICK: begin
				if (sup_phase == hps_pkg::PCODE_RUN) begin
					if (!sup_booted && (sup_unbooted > cfg_timeout_q
						|| sup_unbooted == hps_pkg::CNT_MAX)) begin
						sup_phase = hps_pkg::PCODE_OFF;
						sup_timer = cfg_off_q;
						fired     = 1'b1;
					end else if (sup_delay != 8'd0) begin
						prod = 32'(sup_delay) * 32'(cfg_tps_q);
						if (prod == 0) begin
							sup_delay = 8'd0;
							sup_timer = 12'd0;
							sup_phase = hps_pkg::PCODE_SLEEP;
						end else begin
							sup_timer = prod[11:0];
							sup_phase = hps_pkg::PCODE_DOWN;
						end
					end else if (!sup_booted && sup_unbooted != hps_pkg::CNT_MAX) begin
						sup_unbooted = sup_unbooted + 12'd1;
					end
				end else if (sup_phase == hps_pkg::PCODE_DOWN
					|| sup_phase == hps_pkg::PCODE_OFF) begin
					if (sup_timer <= 12'd1) begin
						sup_timer = 12'd0;
						sup_delay = 8'd0;
						if (sup_phase == hps_pkg::PCODE_DOWN) begin
							sup_phase = hps_pkg::PCODE_SLEEP;
						end else begin
							// The tick that ends a forced cycle is already counted.
							sup_phase    = hps_pkg::PCODE_RUN;
							sup_booted   = 1'b0;
							sup_unbooted = 12'd1;
						end
					end else begin
						sup_timer = sup_timer - 12'd1;
					end
				end
			end
			hps_pkg::OP_BYTE: begin
				// Bytes arriving while asleep are dropped without advancing the pairing.
				if (sup_phase != hps_pkg::PCODE_SLEEP) begin
					if (!sup_data_next) begin
						sup_type      = b;
						sup_data_next = 1'b1;
					end else begin
						sup_data_next = 1'b0;
						if (sup_type == hps_pkg::CMD_DELAY)
							sup_delay = b;
						else if (sup_type == hps_pkg::CMD_BOOT)
							sup_booted = 1'b1;
					end
				end
			end
			hps_pkg::OP_WAKE: begin
				if (sup_phase == hps_pkg::PCODE_SLEEP) begin
					sup_phase    = hps_pkg::PCODE_RUN;
					sup_booted   = 1'b0;
					sup_unbooted = 12'd1;
				end
			end
			default: begin
			end
		endcase
		return word_of(sup_phase <= hps_pkg::PCODE_DOWN, sup_phase, sup_booted, fired);
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("mismatch on status word %0d, %s: expected %0d, got %0d",
			checked_words, what, want, got);
		errors++;
	endtask

	// Presents one word, waits for it to be taken and files its expected status.
	task automatic push_word(logic [1:0] op, logic [7:0] b, bit typed,
			hps_pkg::status_t want);
		hps_pkg::status_t predicted;
		while (feed_idle && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if ((op == hps_pkg::OP_TICK || op == hps_pkg::OP_BYTE)
				? sup_phase != hps_pkg::PCODE_SLEEP
				: (op == hps_pkg::OP_WAKE && sup_phase == hps_pkg::PCODE_SLEEP))
			live_words++;
		predicted = supervise(op, b);
		status_due.push_back(typed ? want : predicted);
	endtask

	task automatic push_tick();
		push_word(hps_pkg::OP_TICK, 8'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers on consecutive edges; the block must be idle.
	task automatic set_config(logic [11:0] timeout, logic [11:0] off_len, logic [3:0] tps);
		cfg_we    <= 1'b1;
		cfg_index <= hps_pkg::REG_BOOT_TIMEOUT;
		cfg_data  <= timeout;
		@(posedge clk);
		cfg_index <= hps_pkg::REG_CYCLE_OFF;
		cfg_data  <= off_len;
		@(posedge clk);
		cfg_index <= hps_pkg::REG_TICKS_PER_S;
		cfg_data  <= {8'd0, tps};
		@(posedge clk);
		cfg_we        <= 1'b0;
		cfg_timeout_q = timeout;
		cfg_off_q     = off_len;
		cfg_tps_q     = tps;
	endtask

	// Mostly well-formed command pairs and tick runs, with stray bytes and noise.
	task automatic run_random(int target);
		int          start;
		int          pick;
		int          n;
		logic [7:0]  cmd;
		logic [7:0]  arg;
		start = live_words;
		while (live_words - start < target) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				push_tick();
			end else if (pick < 52) begin
				n = $urandom_range(40, 5);
				repeat (n) push_tick();
			end else if (pick < 72) begin
				n = $urandom_range(9);
				if (n < 4)
					cmd = hps_pkg::CMD_DELAY;
				else if (n < 8)
					cmd = hps_pkg::CMD_BOOT;
				else
					cmd = 8'($urandom_range(255));
				if (cmd == hps_pkg::CMD_DELAY && $urandom_range(29) != 0)
					arg = 8'($urandom_range(3));
				else
					arg = 8'($urandom_range(255));
				push_word(hps_pkg::OP_BYTE, cmd, 1'b0, '0);
				push_word(hps_pkg::OP_BYTE, arg, 1'b0, '0);
			end else if (pick < 82) begin
				push_word(hps_pkg::OP_WAKE, 8'($urandom_range(255)), 1'b0, '0);
			end else if (pick < 86) begin
				push_word(OP_SPARE, 8'($urandom_range(255)), 1'b0, '0);
			end else begin
				push_word(hps_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b0, '0);
			end
		end
	endtask

	// Status word checker and output back-pressure.
	always @(posedge clk) begin : drain
		hps_pkg::status_t got;
		hps_pkg::status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[4:0];
			if (status_due.size() == 0) begin
				report_mismatch("word with nothing due", 0, int'(m_tdata));
			end else begin
				want = status_due.pop_front();
				if (got.power_enable != want.power_enable)
					report_mismatch("power_enable", int'(want.power_enable),
						int'(got.power_enable));
				if (got.phase != want.phase)
					report_mismatch("phase", int'(want.phase), int'(got.phase));
				if (got.boot_seen != want.boot_seen)
					report_mismatch("boot_seen", int'(want.boot_seen), int'(got.boot_seen));
				if (got.watchdog_fired != want.watchdog_fired)
					report_mismatch("watchdog_fired", int'(want.watchdog_fired),
						int'(got.watchdog_fired));
				if (m_tdata[7:5] != 3'd0)
					report_mismatch("padding", 0, int'(m_tdata[7:5]));
			end
			checked_words++;
		end
		m_tready <= !drain_idle || ($urandom_range(99) >= 36);
	end

	// Watchdog on the run itself.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		sup_phase     = hps_pkg::PCODE_RUN;
		sup_booted    = 1'b0;
		sup_unbooted  = 12'd0;
		sup_delay     = 8'd0;
		sup_timer     = 12'd0;
		sup_data_next = 1'b0;
		sup_type      = 8'd0;
		cfg_timeout_q = hps_pkg::RST_BOOT_TIMEOUT;
		cfg_off_q     = hps_pkg::RST_CYCLE_OFF;
		cfg_tps_q     = hps_pkg::RST_TICKS_PER_S;

		// Directed table, first under the reset register values.
		steps.push_back(want_row(hps_pkg::OP_TICK, 8'h00,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));
		steps.push_back(want_row(OP_SPARE, 8'hFF,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));
		steps.push_back(want_row(hps_pkg::OP_WAKE, 8'h00,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));
		steps.push_back(want_row(hps_pkg::OP_BYTE, hps_pkg::CMD_BOOT,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));
		steps.push_back(want_row(hps_pkg::OP_BYTE, 8'h00,
			1'b1, hps_pkg::PCODE_RUN, 1'b1, 1'b0));
		// An unknown command type only completes a pair.
		steps.push_back(plain_row(hps_pkg::OP_BYTE, 8'hFF));
		steps.push_back(want_row(hps_pkg::OP_BYTE, 8'hFF,
			1'b1, hps_pkg::PCODE_RUN, 1'b1, 1'b0));
		steps.push_back(plain_row(hps_pkg::OP_BYTE, hps_pkg::CMD_DELAY));
		steps.push_back(plain_row(hps_pkg::OP_BYTE, 8'h01));
		steps.push_back(want_row(hps_pkg::OP_TICK, 8'hFF,
			1'b1, hps_pkg::PCODE_DOWN, 1'b1, 1'b0));
		steps.push_back(plain_row(hps_pkg::OP_BYTE, hps_pkg::CMD_BOOT));
		steps.push_back(plain_row(hps_pkg::OP_BYTE, 8'h55));
		repeat (4) steps.push_back(plain_row(hps_pkg::OP_TICK, 8'hAA));
		steps.push_back(want_row(hps_pkg::OP_TICK, 8'h00,
			1'b0, hps_pkg::PCODE_SLEEP, 1'b1, 1'b0));
		// Asleep: bytes and ticks change nothing until the alarm edge.
		steps.push_back(plain_row(hps_pkg::OP_BYTE, hps_pkg::CMD_DELAY));
		steps.push_back(plain_row(hps_pkg::OP_TICK, 8'h00));
		steps.push_back(want_row(hps_pkg::OP_WAKE, 8'hFF,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));
		// Short timeout, zero off time and zero ticks per second.
		steps.push_back(cfg_row(12'd2, 12'd0, 4'd0));
		steps.push_back(plain_row(hps_pkg::OP_TICK, 8'h00));
		steps.push_back(plain_row(hps_pkg::OP_TICK, 8'h00));
		steps.push_back(want_row(hps_pkg::OP_TICK, 8'h00,
			1'b0, hps_pkg::PCODE_OFF, 1'b0, 1'b1));
		steps.push_back(want_row(hps_pkg::OP_TICK, 8'h00,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));
		steps.push_back(plain_row(hps_pkg::OP_BYTE, hps_pkg::CMD_DELAY));
		steps.push_back(plain_row(hps_pkg::OP_BYTE, 8'h07));
		steps.push_back(want_row(hps_pkg::OP_TICK, 8'h00,
			1'b0, hps_pkg::PCODE_SLEEP, 1'b0, 1'b0));
		steps.push_back(want_row(hps_pkg::OP_WAKE, 8'h00,
			1'b1, hps_pkg::PCODE_RUN, 1'b0, 1'b0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed_idle  = 1'b1;
		drain_idle = 1'b1;
		foreach (steps[i]) begin
			if (steps[i].reconf) begin
				wait_idle();
				set_config(steps[i].timeout, steps[i].off_len, steps[i].tps);
			end else begin
				push_word(steps[i].op, steps[i].data, steps[i].typed, steps[i].want);
			end
		end
		wait_idle();

		// No idling on either side: the watchdog fires, the forced cycle runs out,
		// then the largest delay byte gives a countdown of 255 ticks.
		feed_idle  = 1'b0;
		drain_idle = 1'b0;
		set_config(12'd40, 12'd60, 4'd1);
		while (sup_phase == hps_pkg::PCODE_RUN)
			push_tick();
		while (sup_phase == hps_pkg::PCODE_OFF)
			push_tick();
		push_word(hps_pkg::OP_BYTE, hps_pkg::CMD_BOOT, 1'b0, '0);
		push_word(hps_pkg::OP_BYTE, 8'h00, 1'b0, '0);
		push_word(hps_pkg::OP_BYTE, hps_pkg::CMD_DELAY, 1'b0, '0);
		push_word(hps_pkg::OP_BYTE, 8'hFF, 1'b0, '0);
		while (sup_phase != hps_pkg::PCODE_SLEEP)
			push_tick();
		push_word(hps_pkg::OP_WAKE, 8'h00, 1'b0, '0);
		wait_idle();

		// Random traffic over several register settings.
		feed_idle  = 1'b1;
		drain_idle = 1'b1;
		set_config(12'd1, 12'd1, 4'd1);
		run_random(200);
		repeat (4) begin
			wait_idle();
			set_config(12'($urandom_range(60, 1)), 12'($urandom_range(40)),
				4'($urandom_range(15)));
			run_random(250);
		end
		wait_idle();
		set_config(12'd20, 12'd8, 4'd15);
		run_random(200);
		wait_idle();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
